// File: rtl/core/tbdat_pkg.sv
// Shared types and constants of the two-bank deadline alarm timer.
`timescale 1ns / 1ps
`default_nettype none

package tbdat_pkg;

  localparam int RESEND_SLOTS = 8;
  localparam int HALL_SLOTS   = 32;
  localparam int TOTAL_SLOTS  = RESEND_SLOTS + HALL_SLOTS;

  localparam int TIME_W    = 32;
  localparam int TIMEOUT_W = 16;
  localparam int SLOT_W    = 5;
  localparam int IDX_W     = SLOT_W + 1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(10);

  typedef enum logic [1:0] {
    KIND_TICK          = 2'd0,
    KIND_ARM_RESEND    = 2'd1,
    KIND_CANCEL_RESEND = 2'd2,
    KIND_ARM_HALL      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    logic              en;
    logic              arm;
    logic [TIME_W-1:0] deadline;
  } cell_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/tbdat_cell.sv
// One alarm slot: active flag, deadline and the scan token stage of the chain.
`timescale 1ns / 1ps
`default_nettype none

module tbdat_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      token_in,
  input  wire tbdat_pkg::cell_wr_t       wr,
  input  wire logic [tbdat_pkg::TIME_W-1:0] now,
  output logic                           token_out,
  output logic                           hit
);
  import tbdat_pkg::*;

  logic              active_r;
  logic              active_nxt;
  logic              token_r;
  logic [TIME_W-1:0] deadline_r;

  assign hit       = token_r & active_r & (deadline_r <= now);
  assign token_out = token_r;

  always_comb begin
    active_nxt = active_r;
    if (wr.en) begin
      active_nxt = wr.arm;
    end else if (hit) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      token_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      token_r  <= token_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.arm) begin
      deadline_r <= wr.deadline;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/two_bank_deadline_alarm_timer_top.sv
// Top level of the two-bank deadline alarm timer: command decode, scan control and reports.
`timescale 1ns / 1ps
`default_nettype none
// An item is taken on a rising edge with start high and busy low. Its kind
// selects a tick, arming or cancelling a resend slot, or arming a hall slot.
// Arm and cancel items complete in the cycle they are taken and never raise
// busy, so one can be taken in every cycle. A tick increments the time and
// sends a scan token down the row of forty slot cells, one cell per cycle;
// busy stays high while the scan and the flush state after it run, so the next
// item can be taken only after the flush state.
// Each expired slot gives one item on out_bank and out_expired_slot, marked
// by out_valid for one cycle. A report is held until the scan finds the next
// expired slot, and appears in the cycle after that; the final report of the
// tick, marked by out_last, appears in the first cycle with busy low.
// The receiver cannot stall, so reports are simply presented in order.
// The user must write the timeout register through cfg_we and cfg_wdata only while idle;
// the block does not enforce this. Synchronous reset clears the time, all active flags
// and sets the timeout to ten ticks; the block is ready in the first cycle after reset.
module two_bank_deadline_alarm_timer_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [tbdat_pkg::SLOT_W-1:0] in_slot_index,
  output logic                              out_valid,
  output logic                              out_bank,
  output logic [tbdat_pkg::SLOT_W-1:0]      out_expired_slot,
  output logic                              out_last,
  input  wire logic                         cfg_we,
  input  wire logic [tbdat_pkg::TIMEOUT_W-1:0] cfg_wdata
);
  import tbdat_pkg::*;

  state_t               state_r, state_nxt;
  logic [TIME_W-1:0]    tick_count_r, tick_count_nxt;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [IDX_W-1:0]     scan_idx_r, scan_idx_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic                 pend_bank_r, pend_bank_nxt;
  logic [SLOT_W-1:0]    pend_slot_r, pend_slot_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_bank_r, out_bank_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 accept;
  logic                 inject;
  logic                 wr_ok;
  logic                 wr_arm;
  logic [IDX_W-1:0]     wr_idx;
  logic [TIME_W-1:0]    arm_deadline;
  logic [IDX_W-1:0]     idx_sub;
  logic                 scan_bank;
  logic [SLOT_W-1:0]    scan_slot;
  logic                 hit_any;

  cell_wr_t             cell_wr [TOTAL_SLOTS];
  logic [TOTAL_SLOTS-1:0] tok;
  logic [TOTAL_SLOTS-1:0] hit;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign inject = accept && (kind_t'(in_kind) == KIND_TICK);

  assign arm_deadline = tick_count_r + {{(TIME_W-TIMEOUT_W){1'b0}}, timeout_r};

  always_comb begin
    wr_ok  = 1'b0;
    wr_arm = 1'b0;
    wr_idx = {1'b0, in_slot_index};
    unique case (kind_t'(in_kind))
      KIND_ARM_RESEND: begin
        wr_ok  = ({1'b0, in_slot_index} < IDX_W'(RESEND_SLOTS));
        wr_arm = 1'b1;
      end
      KIND_CANCEL_RESEND: begin
        wr_ok  = ({1'b0, in_slot_index} < IDX_W'(RESEND_SLOTS));
      end
      KIND_ARM_HALL: begin
        wr_ok  = ({1'b0, in_slot_index} < IDX_W'(HALL_SLOTS));
        wr_arm = 1'b1;
        wr_idx = {1'b0, in_slot_index} + IDX_W'(RESEND_SLOTS);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < TOTAL_SLOTS; i++) begin
      cell_wr[i].en       = accept && wr_ok && (wr_idx == IDX_W'(i));
      cell_wr[i].arm      = wr_arm;
      cell_wr[i].deadline = arm_deadline;
    end
  end

  for (genvar g = 0; g < TOTAL_SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_head
      tbdat_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .token_in  (inject),
        .wr        (cell_wr[g]),
        .now       (tick_count_r),
        .token_out (tok[g]),
        .hit       (hit[g])
      );
    end else begin : g_body
      tbdat_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .token_in  (tok[g-1]),
        .wr        (cell_wr[g]),
        .now       (tick_count_r),
        .token_out (tok[g]),
        .hit       (hit[g])
      );
    end
  end

  assign hit_any   = |hit;
  assign idx_sub   = scan_idx_r - IDX_W'(RESEND_SLOTS);
  assign scan_bank = (scan_idx_r >= IDX_W'(RESEND_SLOTS));
  assign scan_slot = scan_bank ? idx_sub[SLOT_W-1:0] : scan_idx_r[SLOT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    tick_count_nxt = tick_count_r;
    scan_idx_nxt   = scan_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_bank_nxt  = pend_bank_r;
    pend_slot_nxt  = pend_slot_r;
    out_valid_nxt  = 1'b0;
    out_bank_nxt   = pend_bank_r;
    out_slot_nxt   = pend_slot_r;
    out_last_nxt   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (inject) begin
          tick_count_nxt = tick_count_r + TIME_W'(1);
          scan_idx_nxt   = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_any) begin
          out_valid_nxt  = pend_valid_r;
          pend_valid_nxt = 1'b1;
          pend_bank_nxt  = scan_bank;
          pend_slot_nxt  = scan_slot;
        end
        scan_idx_nxt = scan_idx_r + IDX_W'(1);
        if (scan_idx_r == IDX_W'(TOTAL_SLOTS - 1)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        out_valid_nxt  = pend_valid_r;
        out_last_nxt   = 1'b1;
        pend_valid_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_count_r <= '0;
      timeout_r    <= TIMEOUT_RESET;
      scan_idx_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_count_r <= tick_count_nxt;
      scan_idx_r   <= scan_idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_bank_r <= pend_bank_nxt;
    pend_slot_r <= pend_slot_nxt;
    out_bank_r  <= out_bank_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_bank         = out_bank_r;
  assign out_expired_slot = out_slot_r;
  assign out_last         = out_last_r;

  a_token_single: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok))
    else $error("More than one scan token in the cell row.");

  a_idle_no_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (tok == '0))
    else $error("Scan token present while idle.");

  a_token_tracks_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (tok[scan_idx_r] == 1'b1))
    else $error("Scan token is not at the cell the scan index names.");

  a_last_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> $past(state_r == ST_FLUSH))
    else $error("Final report outside the flush cycle.");

endmodule

`default_nettype wire

// File: sim/two_bank_deadline_alarm_timer_top_tb.sv
// Self-checking testbench of the two-bank deadline alarm timer: directed table then random items.
`timescale 1ns / 1ps

module two_bank_deadline_alarm_timer_top_tb;
  import tbdat_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 54;

  typedef struct packed {
    logic              bank;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } alarm_report_t;

  typedef struct packed {
    bit                   is_cfg;
    logic [TIMEOUT_W-1:0] cfg_value;
    kind_t                kind;
    logic [SLOT_W-1:0]    slot;
    bit                   typed;
    logic [1:0]           n_typed;
    alarm_report_t        r0;
    alarm_report_t        r1;
    alarm_report_t        r2;
  } dir_row_t;

  localparam alarm_report_t NO_REP = '0;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           in_kind = KIND_TICK;
  logic [SLOT_W-1:0]    in_slot_index = '0;
  logic                 out_valid;
  logic                 out_bank;
  logic [SLOT_W-1:0]    out_expired_slot;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic [TIMEOUT_W-1:0] cfg_wdata = '0;

  two_bank_deadline_alarm_timer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_slot_index    (in_slot_index),
    .out_valid        (out_valid),
    .out_bank         (out_bank),
    .out_expired_slot (out_expired_slot),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [TIME_W-1:0]    now_ticks;
  bit                   resend_armed [RESEND_SLOTS];
  logic [TIME_W-1:0]    resend_due [RESEND_SLOTS];
  bit                   hall_armed [HALL_SLOTS];
  logic [TIME_W-1:0]    hall_due [HALL_SLOTS];
  logic [TIMEOUT_W-1:0] alarm_timeout;

  alarm_report_t fired_now[$];
  alarm_report_t pending_reports[$];
  dir_row_t      dir_table[$];

  int  error_count = 0;
  int  items_sent = 0;
  int  ticks_sent = 0;
  int  reports_seen = 0;
  int  cfg_writes = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b1;

  function automatic alarm_report_t rep(logic b, logic [SLOT_W-1:0] s, logic l);
    alarm_report_t r;
    r.bank = b;
    r.slot = s;
    r.last = l;
    return r;
  endfunction

  function automatic dir_row_t item_row(kind_t k, logic [SLOT_W-1:0] s, bit typed,
                                        logic [1:0] n, alarm_report_t a,
                                        alarm_report_t b, alarm_report_t c);
    dir_row_t row;
    row = '0;
    row.kind = k;
    row.slot = s;
    row.typed = typed;
    row.n_typed = n;
    row.r0 = a;
    row.r1 = b;
    row.r2 = c;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [TIMEOUT_W-1:0] v);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.cfg_value = v;
    return row;
  endfunction

  task automatic clear_alarms();
    now_ticks = '0;
    alarm_timeout = TIMEOUT_RESET;
    for (int i = 0; i < RESEND_SLOTS; i++) begin
      resend_armed[i] = 1'b0;
      resend_due[i] = '0;
    end
    for (int i = 0; i < HALL_SLOTS; i++) begin
      hall_armed[i] = 1'b0;
      hall_due[i] = '0;
    end
  endtask

  task automatic advance_alarms(kind_t k, logic [SLOT_W-1:0] s);
    fired_now.delete();
    case (k)
      KIND_ARM_RESEND: begin
        if (s < RESEND_SLOTS) begin
          resend_armed[s] = 1'b1;
          resend_due[s] = now_ticks + TIME_W'(alarm_timeout);
        end
      end
      KIND_CANCEL_RESEND: begin
        if (s < RESEND_SLOTS) resend_armed[s] = 1'b0;
      end
      KIND_ARM_HALL: begin
        if (s < HALL_SLOTS) begin
          hall_armed[s] = 1'b1;
          hall_due[s] = now_ticks + TIME_W'(alarm_timeout);
        end
      end
      default: begin
        now_ticks = now_ticks + 1'b1;
        for (int i = 0; i < RESEND_SLOTS; i++) begin
          if (resend_armed[i] && resend_due[i] <= now_ticks) begin
            resend_armed[i] = 1'b0;
            fired_now.push_back(rep(1'b0, SLOT_W'(i), 1'b0));
          end
        end
        for (int i = 0; i < HALL_SLOTS; i++) begin
          if (hall_armed[i] && hall_due[i] <= now_ticks) begin
            hall_armed[i] = 1'b0;
            fired_now.push_back(rep(1'b1, SLOT_W'(i), 1'b0));
          end
        end
        if (fired_now.size() > 0) fired_now[fired_now.size()-1].last = 1'b1;
      end
    endcase
  endtask

  // Returns once the item has been taken; start is left high for a following item.
  task automatic send_item(kind_t k, logic [SLOT_W-1:0] s);
    int gap;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= k;
    in_slot_index <= s;
    do @(posedge clk); while (busy !== 1'b0);
    items_sent++;
    if (k == KIND_TICK) ticks_sent++;
  endtask

  task automatic write_timeout(logic [TIMEOUT_W-1:0] v);
    start <= 1'b0;
    while (pending_reports.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    alarm_timeout = v;
    cfg_writes++;
  endtask

  task automatic send_random_item();
    int            pick;
    kind_t         k;
    logic [SLOT_W-1:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      k = KIND_TICK;
      s = SLOT_W'($urandom_range(0, 31));
    end else if (pick < 75) begin
      k = (pick < 60) ? KIND_ARM_RESEND : KIND_CANCEL_RESEND;
      if ($urandom_range(0, 99) < 85) s = SLOT_W'($urandom_range(0, RESEND_SLOTS - 1));
      else s = SLOT_W'($urandom_range(0, 31));
    end else begin
      k = KIND_ARM_HALL;
      s = SLOT_W'($urandom_range(0, 31));
    end
    send_item(k, s);
    advance_alarms(k, s);
    foreach (fired_now[i]) pending_reports.push_back(fired_now[i]);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected report: bank %0d slot %0d last %0d",
               out_bank, out_expired_slot, out_last);
        error_count++;
      end else begin
        alarm_report_t want;
        want = pending_reports.pop_front();
        reports_seen++;
        if (out_bank !== want.bank) begin
          $error("out_bank expected %0d actual %0d", want.bank, out_bank);
          error_count++;
        end
        if (out_expired_slot !== want.slot) begin
          $error("out_expired_slot expected %0d actual %0d", want.slot, out_expired_slot);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last expected %0d actual %0d", want.last, out_last);
          error_count++;
        end
      end
    end
  end

  initial begin
    dir_row_t row;
    logic [TIMEOUT_W-1:0] phase_timeout;

    dir_table.push_back(item_row(KIND_TICK, 5'd0, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_ARM_RESEND, 5'd0, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_ARM_HALL, 5'd31, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_ARM_RESEND, 5'd8, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_ARM_RESEND, 5'd31, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_CANCEL_RESEND, 5'd31, 1'b1, 2'd0, NO_REP, NO_REP,
                                 NO_REP));
    dir_table.push_back(item_row(KIND_CANCEL_RESEND, 5'd6, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_ARM_RESEND, 5'd7, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_CANCEL_RESEND, 5'd7, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_ARM_HALL, 5'd0, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    for (int i = 0; i < 9; i++)
      dir_table.push_back(item_row(KIND_TICK, 5'd31, 1'b1, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_TICK, 5'd0, 1'b1, 2'd3, rep(1'b0, 5'd0, 1'b0),
                                 rep(1'b1, 5'd0, 1'b0), rep(1'b1, 5'd31, 1'b1)));
    dir_table.push_back(cfg_row(16'd0));
    dir_table.push_back(item_row(KIND_ARM_RESEND, 5'd3, 1'b0, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_ARM_HALL, 5'd5, 1'b0, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_TICK, 5'd0, 1'b1, 2'd2, rep(1'b0, 5'd3, 1'b0),
                                 rep(1'b1, 5'd5, 1'b1), NO_REP));
    dir_table.push_back(cfg_row(16'hFFFF));
    dir_table.push_back(item_row(KIND_ARM_HALL, 5'd17, 1'b0, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_TICK, 5'd0, 1'b0, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(cfg_row(16'd1));
    dir_table.push_back(item_row(KIND_ARM_RESEND, 5'd2, 1'b0, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_ARM_HALL, 5'd17, 1'b0, 2'd0, NO_REP, NO_REP, NO_REP));
    dir_table.push_back(item_row(KIND_TICK, 5'd0, 1'b0, 2'd0, NO_REP, NO_REP, NO_REP));

    clear_alarms();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_table[i]) begin
      row = dir_table[i];
      if (row.is_cfg) begin
        write_timeout(row.cfg_value);
      end else begin
        send_item(row.kind, row.slot);
        advance_alarms(row.kind, row.slot);
        if (row.typed) begin
          if (row.n_typed > 0) pending_reports.push_back(row.r0);
          if (row.n_typed > 1) pending_reports.push_back(row.r1);
          if (row.n_typed > 2) pending_reports.push_back(row.r2);
        end else begin
          foreach (fired_now[j]) pending_reports.push_back(fired_now[j]);
        end
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: phase_timeout = 16'd1;
        1: phase_timeout = 16'hFFFF;
        2: phase_timeout = 16'd0;
        3: phase_timeout = TIMEOUT_W'($urandom_range(2, 6));
        4: phase_timeout = TIMEOUT_W'($urandom_range(7, 40));
        5: phase_timeout = TIMEOUT_W'($urandom_range(1, 65535));
        6: phase_timeout = 16'd3;
        default: phase_timeout = TIMEOUT_W'($urandom_range(1, 4));
      endcase
      write_timeout(phase_timeout);
      if (p == RAND_PHASES - 1) gaps_on = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_item();
    end

    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d items (%0d ticks), %0d expiry reports checked, %0d timeout writes.",
             items_sent, ticks_sent, reports_seen, cfg_writes);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
